// ===== design/pfa_pkg.sv =====
package pfa_pkg;

  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int IDX_W      = $clog2(NUM_PAGES);
  localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);
  // Room for the rounded-up base, the address and the page offset sum.
  localparam int WIDE_W     = 40;

  localparam int ADDR_W  = 32;
  localparam int FCNT_W  = 16;
  localparam int RCNT_W  = 8;
  localparam int LIMIT_W = 16;
  localparam int APB_AW  = 4;

  localparam int OUT_DATA_W = ADDR_W + FCNT_W + RCNT_W;

  localparam logic [RCNT_W-1:0] RCNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_ADD_REF = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STS_DONE       = 3'd0,
    STS_SHARED     = 3'd1,
    STS_OUT_OF_MEM = 3'd2,
    STS_BAD_ADDR   = 3'd3,
    STS_IN_USE     = 3'd4,
    STS_LIMIT      = 3'd5,
    STS_SATURATED  = 3'd6
  } status_e;

  localparam logic [1:0] REG_REGION_START = 2'd0;
  localparam logic [1:0] REG_REGION_END   = 2'd1;
  localparam logic [1:0] REG_LIMIT_PAGES  = 2'd2;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } chk_t;

endpackage

// ===== design/refcounted_page_frame_allocator.sv =====
// Page-frame allocator with 8-bit reference counts per page and a LIFO free
// stack, both held in single-port-write synchronous RAMs. After reset the
// block runs a clearing pass over the count RAM, one entry per cycle, over
// all NUM_PAGES entries; s_axis_tready stays low meanwhile, while APB
// writes are taken as usual. Software fills the stack by freeing every page
// once. A command is a read-modify-write of the count RAM: an allocate reads
// the stack, then the count, then writes the count back; a free or add
// reference reads the count and writes it back; and a bad address, an empty
// stack or an unused command goes straight to the result. The result sits in
// an output register, so the next command is accepted while it waits to be
// taken. The ref_count of a result is the page's count after the command, and
// free_count the stack depth after it.
module refcounted_page_frame_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pfa_pkg::ADDR_W-1:0]         s_axis_tdata,  // address[31:0]
  input  logic [1:0]                         s_axis_tuser,  // command[1:0]

  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // page_address[31:0], free_count[47:32], ref_count[55:48]
  output logic [pfa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [2:0]                         m_axis_tuser,  // status[2:0]

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pfa_pkg::APB_AW-1:0]         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_STACK,
    ST_REF,
    ST_OUT
  } state_e;

  state_e                              state_q;
  logic [pfa_pkg::IDX_W-1:0]           clr_q;
  logic [1:0]                          cmd_q;
  logic [pfa_pkg::ADDR_W-1:0]          addr_q;
  logic [pfa_pkg::IDX_W-1:0]           idx_q;
  logic [pfa_pkg::DEPTH_W-1:0]         depth_q;
  logic [pfa_pkg::ADDR_W-1:0]          region_start_q;
  logic [pfa_pkg::ADDR_W-1:0]          region_end_q;
  logic [pfa_pkg::LIMIT_W-1:0]         limit_q;
  logic [pfa_pkg::ADDR_W-1:0]          res_addr_q;
  pfa_pkg::status_e                    res_status_q;
  logic [pfa_pkg::RCNT_W-1:0]          res_rc_q;
  logic                                m_valid_q;
  logic [pfa_pkg::OUT_DATA_W-1:0]      m_data_q;
  logic [2:0]                          m_user_q;

  logic [pfa_pkg::WIDE_W-1:0]          base;
  pfa_pkg::chk_t                       chk;

  logic [pfa_pkg::IDX_W-1:0]           stk_rdata;
  logic [pfa_pkg::IDX_W-1:0]           stk_raddr;
  logic                                stk_we;
  logic [pfa_pkg::RCNT_W-1:0]          ref_rdata;
  logic [pfa_pkg::IDX_W-1:0]           ref_raddr;
  logic [pfa_pkg::IDX_W-1:0]           ref_waddr;
  logic [pfa_pkg::RCNT_W-1:0]          ref_wdata;
  logic                                ref_we;

  logic [pfa_pkg::DEPTH_W-1:0]         cap;
  logic                                full;
  logic [pfa_pkg::WIDE_W-1:0]          page_wide;
  logic                                upd_we;
  logic [pfa_pkg::RCNT_W-1:0]          upd_val;
  logic                                push;
  pfa_pkg::status_e                    upd_status;
  logic [pfa_pkg::RCNT_W-1:0]          upd_rc;
  logic [pfa_pkg::ADDR_W-1:0]          upd_addr;
  logic                                cfg_wr;

  pfa_addr_check u_addr_check (
    .region_start_i (region_start_q),
    .region_end_i   (region_end_q),
    .addr_i         (addr_q),
    .base_o         (base),
    .chk_o          (chk)
  );

  pfa_ram #(
    .DEPTH (pfa_pkg::NUM_PAGES),
    .WIDTH (pfa_pkg::IDX_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (pfa_pkg::IDX_W'(depth_q)),
    .wdata_i (idx_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  pfa_ram #(
    .DEPTH (pfa_pkg::NUM_PAGES),
    .WIDTH (pfa_pkg::RCNT_W)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  // The top entry is read during the check cycle, before depth drops.
  assign stk_raddr = pfa_pkg::IDX_W'(depth_q - pfa_pkg::DEPTH_W'(1));
  assign ref_raddr = (state_q == ST_STACK) ? stk_rdata : chk.idx;

  always_comb begin
    if ((limit_q != '0) && (32'(limit_q) < 32'(pfa_pkg::NUM_PAGES))) begin
      cap = pfa_pkg::DEPTH_W'(limit_q);
    end else begin
      cap = pfa_pkg::DEPTH_W'(pfa_pkg::NUM_PAGES);
    end
  end

  assign full      = (depth_q >= cap);
  assign page_wide = base + (pfa_pkg::WIDE_W'(idx_q) << pfa_pkg::PAGE_SHIFT);

  // Count update in the write-back cycle; ref_rdata is the count of idx_q.
  always_comb begin
    upd_we     = 1'b0;
    upd_val    = ref_rdata;
    push       = 1'b0;
    upd_status = pfa_pkg::STS_DONE;
    upd_rc     = '0;
    upd_addr   = '0;
    unique case (cmd_q)
      pfa_pkg::CMD_ALLOC: begin
        if (ref_rdata != '0) begin
          upd_status = pfa_pkg::STS_IN_USE;
          upd_rc     = ref_rdata;
        end else begin
          upd_we   = 1'b1;
          upd_val  = pfa_pkg::RCNT_W'(1);
          upd_rc   = pfa_pkg::RCNT_W'(1);
          upd_addr = page_wide[pfa_pkg::ADDR_W-1:0];
        end
      end
      pfa_pkg::CMD_FREE: begin
        if (ref_rdata > pfa_pkg::RCNT_W'(1)) begin
          upd_we     = 1'b1;
          upd_val    = ref_rdata - pfa_pkg::RCNT_W'(1);
          upd_rc     = upd_val;
          upd_status = pfa_pkg::STS_SHARED;
        end else if (full) begin
          upd_status = pfa_pkg::STS_LIMIT;
          upd_rc     = ref_rdata;
        end else begin
          upd_we  = 1'b1;
          upd_val = '0;
          push    = 1'b1;
        end
      end
      pfa_pkg::CMD_ADD_REF: begin
        if (ref_rdata == pfa_pkg::RCNT_MAX) begin
          upd_status = pfa_pkg::STS_SATURATED;
          upd_rc     = ref_rdata;
        end else begin
          upd_we  = 1'b1;
          upd_val = ref_rdata + pfa_pkg::RCNT_W'(1);
          upd_rc  = upd_val;
        end
      end
      default: begin
        upd_status = pfa_pkg::STS_DONE;
      end
    endcase
  end

  assign ref_we    = (state_q == ST_CLEAR) || ((state_q == ST_REF) && upd_we);
  assign ref_waddr = (state_q == ST_CLEAR) ? clr_q : idx_q;
  assign ref_wdata = (state_q == ST_CLEAR) ? '0 : upd_val;
  assign stk_we    = (state_q == ST_REF) && push;

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      depth_q        <= '0;
      m_valid_q      <= 1'b0;
      region_start_q <= 32'h8000_0000;
      region_end_q   <= 32'h8800_0000;
      limit_q        <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          pfa_pkg::REG_REGION_START: region_start_q <= pwdata;
          pfa_pkg::REG_REGION_END:   region_end_q   <= pwdata;
          pfa_pkg::REG_LIMIT_PAGES:  limit_q        <= pwdata[pfa_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      // In the output state a taken result is replaced by the next one below.
      if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + pfa_pkg::IDX_W'(1);
          if (clr_q == pfa_pkg::IDX_W'(pfa_pkg::NUM_PAGES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q   <= s_axis_tuser;
            addr_q  <= s_axis_tdata;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          res_addr_q <= '0;
          res_rc_q   <= '0;
          unique case (cmd_q)
            pfa_pkg::CMD_ALLOC: begin
              if (depth_q == '0) begin
                res_status_q <= pfa_pkg::STS_OUT_OF_MEM;
                state_q      <= ST_OUT;
              end else begin
                depth_q <= depth_q - pfa_pkg::DEPTH_W'(1);
                state_q <= ST_STACK;
              end
            end
            pfa_pkg::CMD_FREE, pfa_pkg::CMD_ADD_REF: begin
              if (!chk.ok) begin
                res_status_q <= pfa_pkg::STS_BAD_ADDR;
                state_q      <= ST_OUT;
              end else begin
                idx_q   <= chk.idx;
                state_q <= ST_REF;
              end
            end
            default: begin
              res_status_q <= pfa_pkg::STS_DONE;
              state_q      <= ST_OUT;
            end
          endcase
        end
        ST_STACK: begin
          idx_q   <= stk_rdata;
          state_q <= ST_REF;
        end
        ST_REF: begin
          res_addr_q   <= upd_addr;
          res_status_q <= upd_status;
          res_rc_q     <= upd_rc;
          if (push) begin
            depth_q <= depth_q + pfa_pkg::DEPTH_W'(1);
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {res_rc_q, pfa_pkg::FCNT_W'(depth_q), res_addr_q};
            m_user_q  <= res_status_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    unique case (paddr[3:2])
      pfa_pkg::REG_REGION_START: prdata = region_start_q;
      pfa_pkg::REG_REGION_END:   prdata = region_end_q;
      pfa_pkg::REG_LIMIT_PAGES:  prdata = 32'(limit_q);
      default:                   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule

// ===== design/pfa_ram.sv =====
module pfa_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/pfa_addr_check.sv =====
module pfa_addr_check (
  input  logic [pfa_pkg::ADDR_W-1:0] region_start_i,
  input  logic [pfa_pkg::ADDR_W-1:0] region_end_i,
  input  logic [pfa_pkg::ADDR_W-1:0] addr_i,
  output logic [pfa_pkg::WIDE_W-1:0] base_o,
  output pfa_pkg::chk_t              chk_o
);

  logic [pfa_pkg::WIDE_W-1:0] base_up;
  logic [pfa_pkg::WIDE_W-1:0] addr_ext;
  logic [pfa_pkg::WIDE_W-1:0] diff;
  logic [pfa_pkg::WIDE_W-1:0] rel;
  logic                       aligned;

  // The base is region_start rounded up to a page; it may reach 2^32.
  assign base_up  = pfa_pkg::WIDE_W'(region_start_i)
                  + pfa_pkg::WIDE_W'(pfa_pkg::PAGE_BYTES - 1);
  assign base_o   = base_up & ~pfa_pkg::WIDE_W'(pfa_pkg::PAGE_BYTES - 1);
  assign addr_ext = pfa_pkg::WIDE_W'(addr_i);
  assign diff     = addr_ext - base_o;
  assign rel      = diff >> pfa_pkg::PAGE_SHIFT;
  assign aligned  = (addr_i[pfa_pkg::PAGE_SHIFT-1:0] == '0);

  assign chk_o.ok  = aligned && (addr_ext >= base_o) && (addr_i < region_end_i)
                   && (rel < pfa_pkg::WIDE_W'(pfa_pkg::NUM_PAGES));
  assign chk_o.idx = rel[pfa_pkg::IDX_W-1:0];

endmodule

// ===== design/pfa_checker.sv =====
module pfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [2:0]                     m_axis_tuser
);

  logic [pfa_pkg::ADDR_W-1:0] page_addr;
  logic [pfa_pkg::FCNT_W-1:0] free_cnt;
  logic [pfa_pkg::RCNT_W-1:0] ref_cnt;

  assign page_addr = m_axis_tdata[pfa_pkg::ADDR_W-1:0];
  assign free_cnt  = m_axis_tdata[pfa_pkg::ADDR_W +: pfa_pkg::FCNT_W];
  assign ref_cnt   = m_axis_tdata[pfa_pkg::ADDR_W + pfa_pkg::FCNT_W +: pfa_pkg::RCNT_W];

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // An empty stack leaves nothing behind: no page, no count, depth zero.
  a_oom_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pfa_pkg::STS_OUT_OF_MEM) |->
      (page_addr == '0) && (ref_cnt == '0) && (free_cnt == '0))
    else $error("out-of-memory result with stale fields");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(free_cnt) <= 32'(pfa_pkg::NUM_PAGES)))
    else $error("free count beyond page count");

  a_sat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pfa_pkg::STS_SATURATED) |->
      (ref_cnt == pfa_pkg::RCNT_MAX))
    else $error("saturation reported below the maximum count");

  // A shared page keeps at least one reference and yields no address.
  a_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pfa_pkg::STS_SHARED) |->
      (ref_cnt != '0) && (page_addr == '0))
    else $error("shared result with zero count or an address");

endmodule

bind refcounted_page_frame_allocator pfa_checker u_pfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
